@@ rtl/wlhg_pkg.sv @@
// Shared types and constants for the windowed load hysteresis governor.
// No dependencies; imported by every module of the block.
package wlhg_pkg;

  // stream payload widths (whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int FIELD_W     = 32;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] CFG_ADDR_WINDOW    = 4'h0;
  localparam logic [CFG_AW-1:0] CFG_ADDR_FAST_THR  = 4'h4;
  localparam logic [CFG_AW-1:0] CFG_ADDR_SLOW_THR  = 4'h8;
  localparam logic [CFG_AW-1:0] CFG_ADDR_INIT_MODE = 4'hC;

  localparam logic [CFG_DW-1:0] RST_WINDOW    = 32'd1000;
  localparam logic [CFG_DW-1:0] RST_FAST_THR  = 32'd700;
  localparam logic [CFG_DW-1:0] RST_SLOW_THR  = 32'd300;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG,
    ST_START,
    ST_FETCH,
    ST_TEST,
    ST_ACC,
    ST_TAIL,
    ST_TAIL_ADD,
    ST_MODE,
    ST_WAKE,
    ST_OUT
  } state_t;

endpackage

@@ rtl/wlhg_alu.sv @@
// Shared add/subtract unit used for the time sums, differences and threshold compares.
// Depends on wlhg_pkg (alu_op_t).
module wlhg_alu #(
  parameter int W = 32
) (
  input  wlhg_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              cy    // carry out on add, borrow on subtract
);
  import wlhg_pkg::*;

  logic [W:0]   sum;
  logic [W-1:0] b_op;
  logic         is_sub;

  assign is_sub = (op == ALU_SUB);
  assign b_op   = is_sub ? ~b : b;
  assign sum    = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, is_sub};
  assign res    = sum[W-1:0];
  assign cy     = is_sub ? ~sum[W] : sum[W];

endmodule

@@ rtl/wlhg_log.sv @@
// Ring memory of busy-state change records: change time and previous busy flag.
// One write and one registered read port; depends on wlhg_pkg only by convention.
module wlhg_log #(
  parameter int DEPTH = 16,
  parameter int TW    = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [TW-1:0]            wr_time,
  input  logic                     wr_busy,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [TW-1:0]            rd_time,
  output logic                     rd_busy
);
  import wlhg_pkg::*;

  logic [TW-1:0] time_mem [DEPTH];
  logic          busy_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
      busy_mem[wr_addr] <= wr_busy;
    end
  end

  always_ff @(posedge clk) begin
    rd_time <= time_mem[rd_addr];
    rd_busy <= busy_mem[rd_addr];
  end

endmodule

@@ rtl/windowed_load_hysteresis_governor_unit.sv @@
// Windowed load hysteresis governor. Each input transfer carries a tick timestamp and the
// component's busy flag; each one yields exactly one result transfer with the suggested power
// mode, a changed flag, the busy time inside the sliding window and an optional wake-up delay.
// Busy-flag changes are kept in a ring log of HISTORY_DEPTH entries. Work is done by one
// shared add/subtract unit under a sequencer, which per item logs any busy change, forms the
// window start, fetches and tests each log entry visited, adds each busy interval that falls
// in the window, adds the open interval when busy, then compares against the thresholds and
// forms the wake-up delay; with evaluation disabled (zero window) it goes from the log update
// straight to the result. One item is worked at a time; a new one may be accepted while a result waits.
module windowed_load_hysteresis_governor_unit #(
  parameter int HISTORY_DEPTH = 16,
  parameter int TIME_BITS     = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wlhg_pkg::IN_TDATA_W-1:0]    in_tdata,   // now[31:0], busy_req[32]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // power_mode[0], mode_changed[1], busy_time[33:2], wake_valid[34],
  // wake_delay[66:35], history_overflow[67]
  output logic [wlhg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wlhg_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [wlhg_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [wlhg_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import wlhg_pkg::*;

  localparam int TW   = TIME_BITS;
  localparam int CW   = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CNTW = $clog2(HISTORY_DEPTH + 1);

  localparam logic [CW:0]     TM_EXT    = ({{CW{1'b0}}, 1'b1} << TW) - 1'b1;
  localparam logic [CW-1:0]   TIME_MASK = TM_EXT[CW-1:0];
  localparam logic [AW-1:0]   LAST_IDX  = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]     DEPTH_S   = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [CNTW-1:0] DEPTH_C   = CNTW'(HISTORY_DEPTH);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
    wrap_inc = (v == LAST_IDX) ? '0 : v + 1'b1;
  endfunction

  // configuration registers
  logic [CFG_DW-1:0] window_r, fast_thr_r, slow_thr_r;
  logic              init_mode_r;
  logic              cfg_wr;

  // control state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, ptr_r;
  logic [CNTW-1:0] count_r, left_r;
  logic            last_busy_r, mode_r, started_r, prune_r;

  // per-item working registers
  logic [CW-1:0]   now_r, start_r, exec_r, diff_r, wake_delay_r;
  logic            busy_in_r, changed_r, overflow_r, wake_valid_r;

  // output register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_free;

  // shared unit
  alu_op_t       alu_op;
  logic [CW-1:0] alu_a, alu_b, alu_res, sat_res;
  logic          alu_cy;

  // log memory
  logic          log_wr_en;
  logic [AW-1:0] log_wr_addr;
  logic [TW-1:0] log_rd_time;
  logic          log_rd_busy;
  logic [AW:0]   slot_sum;
  logic [CW-1:0] rd_time_ext, win_masked, now_in;
  logic          eval_en, log_full, test_pos;

  wlhg_alu #(.W(CW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .cy  (alu_cy)
  );

  wlhg_log #(.DEPTH(HISTORY_DEPTH), .TW(TW)) u_log (
    .clk     (clk),
    .wr_en   (log_wr_en),
    .wr_addr (log_wr_addr),
    .wr_time (now_r[TW-1:0]),
    .wr_busy (last_busy_r),
    .rd_addr (ptr_r),
    .rd_time (log_rd_time),
    .rd_busy (log_rd_busy)
  );

  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign eval_en     = (window_r != '0);
  assign win_masked  = CW'(window_r) & TIME_MASK;
  assign now_in      = CW'(in_tdata[FIELD_W-1:0]) & TIME_MASK;
  assign rd_time_ext = CW'(log_rd_time);
  assign log_full    = (count_r == DEPTH_C);
  assign slot_sum    = {1'b0, head_r} + (AW + 1)'(count_r);
  assign sat_res     = (alu_cy || alu_res > TIME_MASK) ? TIME_MASK : alu_res;
  assign test_pos    = !alu_cy && (alu_res != '0);
  assign out_free    = !out_tvalid_r || out_tready;
  assign out_tvalid  = out_tvalid_r;
  assign out_tdata   = out_tdata_r;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr)
      CFG_ADDR_WINDOW:    cfg_prdata = window_r;
      CFG_ADDR_FAST_THR:  cfg_prdata = fast_thr_r;
      CFG_ADDR_SLOW_THR:  cfg_prdata = slow_thr_r;
      CFG_ADDR_INIT_MODE: cfg_prdata = {{(CFG_DW-1){1'b0}}, init_mode_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= RST_WINDOW;
      fast_thr_r  <= RST_FAST_THR;
      slow_thr_r  <= RST_SLOW_THR;
      init_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        CFG_ADDR_WINDOW:    window_r    <= cfg_pwdata;
        CFG_ADDR_FAST_THR:  fast_thr_r  <= cfg_pwdata;
        CFG_ADDR_SLOW_THR:  slow_thr_r  <= cfg_pwdata;
        CFG_ADDR_INIT_MODE: init_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_LOG;
      ST_LOG:      state_nxt = eval_en ? ST_START : ST_OUT;
      ST_START:    state_nxt = ST_FETCH;
      ST_FETCH:    state_nxt = (left_r == '0) ? ST_TAIL : ST_TEST;
      ST_TEST:     state_nxt = (test_pos && log_rd_busy) ? ST_ACC : ST_FETCH;
      ST_ACC:      state_nxt = ST_FETCH;
      ST_TAIL:     state_nxt = (last_busy_r && !alu_cy) ? ST_TAIL_ADD : ST_MODE;
      ST_TAIL_ADD: state_nxt = ST_MODE;
      ST_MODE:     state_nxt = ST_WAKE;
      ST_WAKE:     state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, log write, operand selection
  always_comb begin
    in_tready   = 1'b0;
    log_wr_en   = 1'b0;
    log_wr_addr = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : slot_sum[AW-1:0];
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_LOG: begin
        log_wr_en = (busy_in_r != last_busy_r);
        // full log: the new entry takes the oldest slot
        if (log_full) log_wr_addr = head_r;
      end
      ST_START: begin
        alu_op = ALU_SUB;
        alu_a  = now_r;
        alu_b  = win_masked;
      end
      ST_TEST: begin
        alu_op = ALU_SUB;
        alu_a  = rd_time_ext;
        alu_b  = start_r;
      end
      ST_ACC, ST_TAIL_ADD: begin
        alu_a = exec_r;
        alu_b = diff_r;
      end
      ST_TAIL: begin
        alu_op = ALU_SUB;
        alu_a  = now_r;
        alu_b  = start_r;
      end
      ST_MODE: begin
        alu_op = ALU_SUB;
        alu_a  = mode_r ? CW'(slow_thr_r) : exec_r;
        alu_b  = mode_r ? exec_r : CW'(fast_thr_r);
      end
      ST_WAKE: begin
        alu_op = ALU_SUB;
        alu_a  = mode_r ? exec_r : CW'(fast_thr_r);
        alu_b  = mode_r ? CW'(slow_thr_r) : exec_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      last_busy_r <= 1'b0;
      mode_r      <= 1'b0;
      started_r   <= 1'b0;
      ptr_r       <= '0;
      left_r      <= '0;
      prune_r     <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && !started_r) begin
            started_r <= 1'b1;
            mode_r    <= init_mode_r;
          end
        end
        ST_LOG: begin
          if (busy_in_r != last_busy_r) begin
            last_busy_r <= busy_in_r;
            if (log_full) head_r  <= wrap_inc(head_r);
            else          count_r <= count_r + 1'b1;
          end
        end
        ST_START: begin
          ptr_r   <= head_r;
          left_r  <= count_r;
          prune_r <= 1'b1;
        end
        ST_TEST: begin
          ptr_r  <= wrap_inc(ptr_r);
          left_r <= left_r - 1'b1;
          if (alu_cy) begin
            // older than the window start: drop while still at the front
            if (prune_r) begin
              head_r  <= wrap_inc(head_r);
              count_r <= count_r - 1'b1;
            end
          end else begin
            prune_r <= 1'b0;
          end
        end
        ST_MODE: begin
          if (!alu_cy) mode_r <= ~mode_r;
        end
        default: ;
      endcase
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        now_r        <= now_in;
        busy_in_r    <= in_tdata[FIELD_W];
        changed_r    <= !started_r;
        overflow_r   <= 1'b0;
        exec_r       <= '0;
        wake_valid_r <= 1'b0;
        wake_delay_r <= '0;
      end
      ST_LOG: begin
        if (busy_in_r != last_busy_r && log_full) overflow_r <= 1'b1;
      end
      ST_START: start_r <= alu_cy ? '0 : alu_res;
      ST_TEST: begin
        if (test_pos) begin
          start_r <= rd_time_ext;
          diff_r  <= alu_res;
        end
      end
      ST_TAIL:     diff_r <= alu_res;
      ST_ACC:      exec_r <= sat_res;
      ST_TAIL_ADD: exec_r <= sat_res;
      ST_MODE: begin
        if (!alu_cy) changed_r <= 1'b1;
      end
      ST_WAKE: begin
        if (mode_r != last_busy_r) begin
          wake_valid_r <= 1'b1;
          wake_delay_r <= alu_cy ? '0 : alu_res;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_tdata_r <= {4'b0000, overflow_r, wake_delay_r[FIELD_W-1:0], wake_valid_r,
                      exec_r[FIELD_W-1:0], changed_r, mode_r};
    end
  end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for windowed_load_hysteresis_governor_unit: drives timestamp/busy
// transfers and APB register writes, predicts each result in-bench and compares it.
// Depends on rtl/wlhg_pkg.sv and the unit's RTL only.
module tb;
  import wlhg_pkg::*;

  localparam int          LOG_DEPTH      = 16;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          END_SETTLE     = 60;
  localparam int          VERDICT_SLOTS  = 16;
  localparam logic        MODE_SLOW      = 1'b0;
  localparam logic        MODE_FAST      = 1'b1;
  localparam logic [31:0] TICK_MAX       = 32'hFFFF_FFFF;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // now[31:0], busy_req[32]
  logic                   out_tvalid;
  logic                   out_tready;
  // power_mode[0], mode_changed[1], busy_time[33:2], wake_valid[34],
  // wake_delay[66:35], history_overflow[67]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  windowed_load_hysteresis_governor_unit #(
    .HISTORY_DEPTH(LOG_DEPTH),
    .TIME_BITS    (32)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic        mode;
    logic        changed;
    logic [31:0] busy_time;
    logic        wake_valid;
    logic [31:0] wake_delay;
    logic        overflow;
  } gov_verdict_t;

  // expected results in order of acceptance
  gov_verdict_t verdict_ring [VERDICT_SLOTS];
  int unsigned  verdict_wr = 0;
  int unsigned  verdict_rd = 0;

  // governor state as the bench sees it
  logic [31:0] reg_window    = RST_WINDOW;
  logic [31:0] reg_fast      = RST_FAST_THR;
  logic [31:0] reg_slow      = RST_SLOW_THR;
  logic        reg_init_mode = MODE_SLOW;
  logic [31:0] log_stamp    [LOG_DEPTH];
  logic        log_was_busy [LOG_DEPTH];
  int unsigned log_head      = 0;
  int unsigned log_count     = 0;
  logic        gov_last_busy = 1'b0;
  logic        gov_mode      = MODE_SLOW;
  logic        gov_started   = 1'b0;

  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles  = 0;
  int unsigned quiet_cycles  = 0;

  function automatic int unsigned verdicts_pending();
    return verdict_wr - verdict_rd;
  endfunction

  function automatic logic [32:0] add_sat(logic [32:0] acc, logic [31:0] delta);
    logic [32:0] total;
    total = acc + {1'b0, delta};
    return total[32] ? {1'b0, TICK_MAX} : total;
  endfunction

  function automatic gov_verdict_t govern_step(logic [31:0] now, logic busy);
    gov_verdict_t v;
    logic [32:0]  busy_sum;
    logic [31:0]  win_start;
    logic [31:0]  stamp;
    int unsigned  slot;
    v = '{default: '0};
    busy_sum = '0;
    if (!gov_started) begin
      gov_started = 1'b1;
      gov_mode = reg_init_mode;
      v.changed = 1'b1;
    end
    if (busy != gov_last_busy) begin
      if (log_count >= LOG_DEPTH) begin
        log_head = (log_head + 1) % LOG_DEPTH;
        log_count = LOG_DEPTH - 1;
        v.overflow = 1'b1;
      end
      slot = (log_head + log_count) % LOG_DEPTH;
      log_stamp[slot] = now;
      log_was_busy[slot] = gov_last_busy;
      log_count++;
      gov_last_busy = busy;
    end
    if (reg_window != '0) begin
      win_start = (now > reg_window) ? now - reg_window : '0;
      while (log_count > 0 && log_stamp[log_head] < win_start) begin
        log_head = (log_head + 1) % LOG_DEPTH;
        log_count--;
      end
      // window start only moves forward, so stale stamps add nothing
      for (int unsigned i = 0; i < log_count; i++) begin
        slot = (log_head + i) % LOG_DEPTH;
        stamp = log_stamp[slot];
        if (stamp > win_start) begin
          if (log_was_busy[slot]) busy_sum = add_sat(busy_sum, stamp - win_start);
          win_start = stamp;
        end
      end
      if (gov_last_busy && now > win_start) busy_sum = add_sat(busy_sum, now - win_start);

      if (gov_mode == MODE_SLOW && busy_sum >= {1'b0, reg_fast}) begin
        gov_mode = MODE_FAST;
        v.changed = 1'b1;
      end else if (gov_mode == MODE_FAST && busy_sum <= {1'b0, reg_slow}) begin
        gov_mode = MODE_SLOW;
        v.changed = 1'b1;
      end

      if (gov_mode == MODE_SLOW && gov_last_busy) begin
        v.wake_valid = 1'b1;
        v.wake_delay = ({1'b0, reg_fast} > busy_sum) ? reg_fast - busy_sum[31:0] : '0;
      end else if (gov_mode == MODE_FAST && !gov_last_busy) begin
        v.wake_valid = 1'b1;
        v.wake_delay = (busy_sum > {1'b0, reg_slow}) ? busy_sum[31:0] - reg_slow : '0;
      end
    end
    v.mode = gov_mode;
    v.busy_time = busy_sum[31:0];
    return v;
  endfunction

  function automatic logic [31:0] reg_value(logic [CFG_AW-1:0] addr);
    case (addr)
      CFG_ADDR_WINDOW:    return reg_window;
      CFG_ADDR_FAST_THR:  return reg_fast;
      CFG_ADDR_SLOW_THR:  return reg_slow;
      CFG_ADDR_INIT_MODE: return {31'b0, reg_init_mode};
      default:            return '0;
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) note_mismatch($sformatf("%s expected %0h got %0h", name, expv, actv));
  endtask

  // one APB access; a single idle cycle follows so psel drops between back-to-back calls
  task automatic apb_access(logic wr, logic [CFG_AW-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(logic [CFG_AW-1:0] addr);
    logic [31:0] rd;
    apb_access(1'b0, addr, '0, rd);
    check_field($sformatf("register %0h", addr), reg_value(addr), rd);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    logic [31:0] unused;
    apb_access(1'b1, addr, data, unused);
    case (addr)
      CFG_ADDR_WINDOW:    reg_window = data;
      CFG_ADDR_FAST_THR:  reg_fast = data;
      CFG_ADDR_SLOW_THR:  reg_slow = data;
      CFG_ADDR_INIT_MODE: reg_init_mode = data[0];
      default: ;
    endcase
    cfg_read_check(addr);
  endtask

  task automatic configure(logic [31:0] window, logic [31:0] fast, logic [31:0] slow,
                           logic init_mode);
    cfg_write(CFG_ADDR_WINDOW, window);
    cfg_write(CFG_ADDR_FAST_THR, fast);
    cfg_write(CFG_ADDR_SLOW_THR, slow);
    cfg_write(CFG_ADDR_INIT_MODE, {31'b0, init_mode});
  endtask

  // offer one timestamp; the prediction is taken at the accepting edge
  task automatic offer_tick(logic [31:0] now, logic busy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, busy, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    verdict_ring[verdict_wr % VERDICT_SLOTS] = govern_step(now, busy);
    verdict_wr++;
  endtask

  // sender pauses until every result is back; the block is then idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdicts_pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: random back-pressure, or a long hold-off when asked
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        out_tready <= 1'b0;
        stall_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    gov_verdict_t ev;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_pending() == 0) begin
        note_mismatch($sformatf("result transfer with none expected, tdata %h", out_tdata));
      end else begin
        ev = verdict_ring[verdict_rd % VERDICT_SLOTS];
        verdict_rd++;
        check_field("power_mode", {31'b0, ev.mode}, {31'b0, out_tdata[0]});
        check_field("mode_changed", {31'b0, ev.changed}, {31'b0, out_tdata[1]});
        check_field("busy_time", ev.busy_time, out_tdata[33:2]);
        check_field("wake_valid", {31'b0, ev.wake_valid}, {31'b0, out_tdata[34]});
        check_field("wake_delay", ev.wake_delay, out_tdata[66:35]);
        check_field("history_overflow", {31'b0, ev.overflow}, {31'b0, out_tdata[67]});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_register_defaults();
    cfg_read_check(CFG_ADDR_WINDOW);
    cfg_read_check(CFG_ADDR_FAST_THR);
    cfg_read_check(CFG_ADDR_SLOW_THR);
    cfg_read_check(CFG_ADDR_INIT_MODE);
  endtask

  // first transfer adopts the initial mode and flags a change
  task automatic test_first_item();
    cfg_write(CFG_ADDR_INIT_MODE, {31'b0, MODE_FAST});
    offer_tick(32'd0, 1'b0);
    offer_tick(32'd10, 1'b1);
    offer_tick(32'd800, 1'b1);
    offer_tick(32'd800, 1'b0);
    offer_tick(32'd1200, 1'b0);
    offer_tick(32'd1700, 1'b0);
    drain();
  endtask

  // nothing ages out of a full-range window, so the log fills and drops its oldest
  task automatic test_log_overflow();
    cfg_write(CFG_ADDR_WINDOW, TICK_MAX);
    for (int i = 0; i < 20; i++) offer_tick(32'd2000 + 3 * i, !gov_last_busy);
    drain();
  endtask

  task automatic test_zero_window();
    cfg_write(CFG_ADDR_WINDOW, '0);
    offer_tick(32'd3000, 1'b1);
    offer_tick(32'd3100, 1'b0);
    offer_tick(32'd3100, 1'b0);
    drain();
  endtask

  task automatic test_time_backwards();
    cfg_write(CFG_ADDR_WINDOW, RST_WINDOW);
    offer_tick(TICK_MAX, 1'b1);
    offer_tick(32'hFFFF_FFF0, 1'b0);
    offer_tick(32'd5, 1'b1);
    offer_tick(32'd0, 1'b0);
    drain();
  endtask

  // long receiver hold-off while transfers keep coming, then a full drain
  task automatic test_backpressure();
    logic [31:0] t_now;
    t_now = 32'd10_000;
    cfg_write(CFG_ADDR_WINDOW, 32'd1500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles = 300;
    for (int i = 0; i < 24; i++) begin
      t_now = t_now + $urandom_range(0, 200);
      offer_tick(t_now, 1'($urandom_range(1)));
    end
    drain();
  endtask

  task automatic test_random();
    logic [31:0] t_now;
    logic [31:0] stride_max;
    logic [31:0] win;
    logic [31:0] fast;
    logic        busy;
    int unsigned roll;
    t_now = 32'd20_000;
    busy = 1'b0;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin
          win = $urandom_range(500, 2000);
          fast = $urandom_range(0, win);
          configure(win, fast, $urandom_range(0, fast), MODE_SLOW);
        end
        1: begin
          win = $urandom_range(1, 40);
          fast = $urandom_range(0, win);
          configure(win, fast, $urandom_range(0, fast), MODE_FAST);
        end
        2: configure(TICK_MAX, '0, TICK_MAX, MODE_SLOW);
        3: begin
          configure($urandom, $urandom, $urandom, 1'($urandom_range(1)));
          t_now = $urandom;
        end
        4: configure($urandom_range(100, 3000), TICK_MAX, '0, MODE_FAST);
        default: begin
          win = $urandom_range(200, 1500);
          configure(win, $urandom_range(win / 4, win), $urandom_range(0, win / 4), MODE_SLOW);
        end
      endcase
      stride_max = (reg_window == '0 || reg_window > 32'd10_000) ? 32'd1000
                                                                  : reg_window / 6 + 1;
      send_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 68 : 0;
      recv_idle_pct = (seg < 2) ? 68 : (seg < 4) ? 38 : 0;
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(99);
        if (roll < 3) t_now = $urandom;
        else if (roll < 8) t_now = t_now - $urandom_range(0, stride_max);
        else t_now = t_now + $urandom_range(0, stride_max);
        if ($urandom_range(99) < 45) busy = !busy;
        offer_tick(t_now, busy);
      end
      drain();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_first_item();
    test_log_overflow();
    test_zero_window();
    test_time_backwards();
    test_backpressure();
    test_random();

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && verdicts_pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
